// File: hdl/lrgd_pkg.sv
package lrgd_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int DATA_WIDTH_DEF = 16;

  localparam logic [31:0] LR_RESET    = 32'd429497;
  localparam logic [15:0] EPOCH_RESET = 16'd1000;

  // Divider: 96-bit dividend, one quotient bit per cycle
  localparam int DIV_STEPS = 96;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam logic signed [65:0] Q_MAX66 = 66'sd140737488355327;
  localparam logic signed [65:0] Q_MIN66 = -66'sd140737488355328;
  localparam logic signed [47:0] Q_MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Q_MIN48 = 48'sh8000_0000_0000;
  localparam logic signed [65:0] ONE_Q66 = 66'sd4294967296;

  // APB register indexes
  localparam logic REG_LEARNING_RATE = 1'b0;
  localparam logic REG_EPOCH_COUNT   = 1'b1;

  typedef enum logic [5:0] {
    ST_LOAD, ST_TRAIN_INIT, ST_EPOCH_CHECK, ST_EPOCH_INIT,
    ST_G_READ, ST_G_PMUL, ST_G_PADD, ST_G_ERR, ST_G_GMUL, ST_G_ACC,
    ST_DIV_START, ST_DIV_WAIT, ST_CAP_G, ST_RATE_MUL, ST_RATE_SUM, ST_UPDATE,
    ST_SCORE_INIT, ST_Y_READ, ST_Y_ACC, ST_MEAN_START, ST_MEAN_WAIT, ST_MEAN_CAP,
    ST_S_READ, ST_S_PMUL, ST_S_PADD, ST_S_DEV, ST_S_SQ, ST_S_ACC,
    ST_RATIO_CHECK, ST_RATIO_START, ST_RATIO_WAIT, ST_FINAL, ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_STORE, OP_TRAIN_INIT, OP_EPOCH_INIT, OP_PRED_MUL, OP_PRED_ADD,
    OP_ERR, OP_GRAD_MUL, OP_GRAD_ACC, OP_DIV_G, OP_CAP_G, OP_RATE_MUL,
    OP_RATE_SUM, OP_UPDATE, OP_SCORE_INIT, OP_Y_ACC, OP_DIV_MEAN, OP_CAP_MEAN,
    OP_DEV, OP_SQ, OP_SQ_ACC, OP_DIV_RATIO, OP_FINAL, OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic target;    // 0 slope, 1 intercept
    logic use_prev;  // predict with pre-update parameters
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic epochs_done;
    logic div_busy;
    logic out_full;
    logic tot_zero;
  } status_t;

  function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
    logic signed [47:0] r;
    if (v > Q_MAX66) begin
      r = Q_MAX48;
    end else if (v < Q_MIN66) begin
      r = Q_MIN48;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      r = s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] uadd_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  // Deviation magnitude in Q16.16, capped to 32 bits
  function automatic logic [31:0] dev_mag(input logic signed [65:0] d);
    logic [65:0] mag;
    logic [65:0] sh;
    mag = d[65] ? 66'(-d) : 66'(d);
    sh  = mag >> 16;
    return (|sh[65:32]) ? 32'hFFFF_FFFF : sh[31:0];
  endfunction

endpackage

// File: hdl/linear_regression_gradient_descent.sv
// Simple linear regression trained by full-batch gradient descent in signed
// Q16.32 fixed point. Points (x,y) stream in one per cycle and are stored (up
// to MAX_POINTS; extras are dropped) until a request arrives with tlast set.
// Slope and intercept then start at zero and run epoch_count epochs; each
// epoch walks all n stored points (read, predict, error, gradient,
// accumulate) and then runs two divisions by n on the shared bit-serial
// divider, one for each parameter. Scoring sums the targets, divides for
// the mean, makes a residual pass and a ratio division (skipped when the
// target variance is zero). Only one data set is in flight; the result
// (slope, intercept, R-squared score, status) sits in an output register,
// and loading of the next set starts as soon as it is captured there.
// learning_rate (unsigned Q0.32) sits at APB address 0x0, epoch_count at
// 0x4; write them only while the block is idle.
module linear_regression_gradient_descent #(
  parameter int MAX_POINTS = lrgd_pkg::MAX_POINTS_DEF,
  parameter int DATA_WIDTH = lrgd_pkg::DATA_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // APB configuration
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [2:0]                                paddr,
  input  logic [31:0]                               pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready,
  // point stream
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // tdata: sample_x, sample_y (lowest bit up), zero padded to bytes
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
  input  logic                                      s_axis_tlast,   // last_point
  // result stream
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // tdata: slope, intercept, fit_score (lowest bit up)
  output logic [143:0]                              m_axis_tdata,
  output logic                                      m_axis_tuser    // status
);
  import lrgd_pkg::*;

  logic [31:0] learning_rate;
  logic [15:0] epoch_count;
  logic        cfg_write;

  cmd_t    cmd;
  status_t status;

  logic signed [DATA_WIDTH-1:0] sample_x, sample_y;
  logic signed [47:0]           out_slope, out_intercept, out_fit;

  // Register file: write on the access phase of an APB request
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= LR_RESET;
      epoch_count   <= EPOCH_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_LEARNING_RATE: learning_rate <= pwdata;
        REG_EPOCH_COUNT:   epoch_count   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LEARNING_RATE: prdata = learning_rate;
      REG_EPOCH_COUNT:   prdata = {16'd0, epoch_count};
      default:           prdata = '0;
    endcase
  end

  assign sample_x = s_axis_tdata[DATA_WIDTH-1:0];
  assign sample_y = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

  lrgd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lrgd_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .sample_x      (sample_x),
    .sample_y      (sample_y),
    .learning_rate (learning_rate),
    .epoch_count   (epoch_count),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_slope     (out_slope),
    .out_intercept (out_intercept),
    .out_fit       (out_fit),
    .out_status    (m_axis_tuser)
  );

  assign m_axis_tdata = {out_fit, out_intercept, out_slope};

endmodule

// File: hdl/lrgd_div.sv
module lrgd_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [95:0]  dividend,
  input  logic [63:0]  divisor,
  output logic         busy,
  output logic [95:0]  quotient
);
  import lrgd_pkg::*;

  logic [63:0]       rem;
  logic [95:0]       dvd;
  logic [63:0]       dsr;
  logic [DIV_CW-1:0] cnt;
  logic [64:0]       trial;
  logic [64:0]       diff;

  assign trial = {rem, dvd[95]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CW'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvd      <= dividend;
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      dvd <= {dvd[94:0], 1'b0};
      if (!diff[64]) begin
        rem      <= diff[63:0];
        quotient <= {quotient[94:0], 1'b1};
      end else begin
        rem      <= trial[63:0];
        quotient <= {quotient[94:0], 1'b0};
      end
    end
  end

endmodule

// File: hdl/lrgd_datapath.sv
module lrgd_datapath #(
  parameter int MAX_POINTS = lrgd_pkg::MAX_POINTS_DEF,
  parameter int DATA_WIDTH = lrgd_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lrgd_pkg::cmd_t               cmd,
  output lrgd_pkg::status_t            status,
  input  logic signed [DATA_WIDTH-1:0] sample_x,
  input  logic signed [DATA_WIDTH-1:0] sample_y,
  input  logic [31:0]                  learning_rate,
  input  logic [15:0]                  epoch_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [47:0]           out_slope,
  output logic signed [47:0]           out_intercept,
  output logic signed [47:0]           out_fit,
  output logic                         out_status
);
  import lrgd_pkg::*;

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int YSW = 16 + CW;
  localparam logic [63:0] G_LIM_NEG = 64'h0000_8000_0000_0000;
  localparam logic [63:0] G_LIM_POS = 64'h0000_7FFF_FFFF_FFFF;

  logic signed [15:0] x_mem [MAX_POINTS];
  logic signed [15:0] y_mem [MAX_POINTS];

  logic [CW-1:0]       count;
  logic [CW-1:0]       idx;
  logic signed [15:0]  x_q, y_q;
  logic signed [47:0]  slope, intercept, prev_slope, prev_intercept;
  logic signed [63:0]  mprod, gprod, sum_m, sum_c, mean;
  logic signed [47:0]  pred, err;
  logic                g_neg;
  logic [47:0]         g_mag, step, prod_lo;
  logic [63:0]         prod_hi;
  logic [15:0]         epoch_cnt;
  logic signed [YSW-1:0] ysum;
  logic [31:0]         dev_t, dev_r;
  logic [63:0]         sq_t, sq_r, tot, res;
  logic                div_neg;
  logic signed [47:0]  fit;
  logic                degen;

  logic                div_start, div_busy;
  logic [95:0]         div_dividend, div_quotient;
  logic [63:0]         div_divisor;

  logic signed [31:0]  x_ext, y_ext;
  logic signed [15:0]  x_sat, y_sat;
  logic signed [47:0]  yq;
  logic signed [63:0]  g_sum, g_sum2, g_abs_s;
  logic [YSW-1:0]      ysum_mag;
  logic [63:0]         q64;
  logic signed [47:0]  upd_param;
  logic signed [65:0]  step_s;
  logic [64:0]         rate_acc;

  lrgd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  // Wide samples clamp to the 16-bit range
  always_comb begin
    x_ext = 32'(sample_x);
    y_ext = 32'(sample_y);
    x_sat = (x_ext > 32'sd32767) ? 16'sh7FFF :
            (x_ext < -32'sd32768) ? 16'sh8000 : x_ext[15:0];
    y_sat = (y_ext > 32'sd32767) ? 16'sh7FFF :
            (y_ext < -32'sd32768) ? 16'sh8000 : y_ext[15:0];
  end

  assign yq = $signed({y_q, 32'd0});

  // Divider operand selection
  always_comb begin
    g_sum   = cmd.target ? sum_c : sum_m;
    g_sum2  = (g_sum[63] != g_sum[62]) ?
              (g_sum[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF) :
              (g_sum <<< 1);
    g_abs_s = g_sum2[63] ? -g_sum2 : g_sum2;
    ysum_mag = ysum[YSW-1] ? YSW'(-ysum) : YSW'(ysum);
    div_start    = 1'b0;
    div_dividend = {32'd0, g_abs_s};
    div_divisor  = 64'(count);
    case (cmd.op)
      OP_DIV_G: begin
        div_start = 1'b1;
      end
      OP_DIV_MEAN: begin
        div_start    = 1'b1;
        div_dividend = 96'({ysum_mag, 32'd0});
      end
      OP_DIV_RATIO: begin
        div_start    = 1'b1;
        div_dividend = {res, 32'd0};
        div_divisor  = tot;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    q64       = div_quotient[63:0];
    upd_param = cmd.target ? intercept : slope;
    step_s    = $signed({18'd0, step});
    rate_acc  = {1'b0, prod_hi} + 65'(prod_lo[47:16]);
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_STORE && count < CW'(MAX_POINTS)) begin
      x_mem[count[AW-1:0]] <= x_sat;
      y_mem[count[AW-1:0]] <= y_sat;
    end
    x_q <= x_mem[idx[AW-1:0]];
    y_q <= y_mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      idx            <= '0;
      slope          <= '0;
      intercept      <= '0;
      prev_slope     <= '0;
      prev_intercept <= '0;
      sum_m          <= '0;
      sum_c          <= '0;
      epoch_cnt      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ready && cmd.op != OP_OUT) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_STORE: begin
          if (count < CW'(MAX_POINTS)) begin
            count <= count + 1'b1;
          end
        end
        OP_TRAIN_INIT: begin
          slope          <= '0;
          intercept      <= '0;
          prev_slope     <= '0;
          prev_intercept <= '0;
          epoch_cnt      <= '0;
        end
        OP_EPOCH_INIT: begin
          prev_slope     <= slope;
          prev_intercept <= intercept;
          sum_m          <= '0;
          sum_c          <= '0;
          idx            <= '0;
        end
        OP_PRED_MUL: begin
          mprod <= (cmd.use_prev ? prev_slope : slope) * x_q;
        end
        OP_PRED_ADD: begin
          pred <= sat48(66'(mprod) + 66'(cmd.use_prev ? prev_intercept : intercept));
        end
        OP_ERR: begin
          err <= sat48(66'(pred) - 66'(yq));
        end
        OP_GRAD_MUL: begin
          gprod <= err * x_q;
        end
        OP_GRAD_ACC: begin
          sum_m <= sadd64(sum_m, gprod);
          sum_c <= sadd64(sum_c, 64'(err));
          idx   <= idx + 1'b1;
        end
        OP_DIV_G: begin
          div_neg <= g_sum2[63];
        end
        OP_CAP_G: begin
          g_neg <= div_neg;
          if (div_neg) begin
            g_mag <= (q64 > G_LIM_NEG) ? G_LIM_NEG[47:0] : q64[47:0];
          end else begin
            g_mag <= (q64 > G_LIM_POS) ? G_LIM_POS[47:0] : q64[47:0];
          end
        end
        OP_RATE_MUL: begin
          prod_hi <= 64'(g_mag[47:16]) * 64'(learning_rate);
          prod_lo <= 48'(g_mag[15:0]) * 48'(learning_rate);
        end
        OP_RATE_SUM: begin
          step <= rate_acc[63:16];
        end
        OP_UPDATE: begin
          if (cmd.target) begin
            intercept <= sat48(g_neg ? 66'(upd_param) + step_s : 66'(upd_param) - step_s);
            epoch_cnt <= epoch_cnt + 1'b1;
          end else begin
            slope <= sat48(g_neg ? 66'(upd_param) + step_s : 66'(upd_param) - step_s);
          end
        end
        OP_SCORE_INIT: begin
          ysum <= '0;
          idx  <= '0;
        end
        OP_Y_ACC: begin
          ysum <= ysum + YSW'(y_q);
          idx  <= idx + 1'b1;
        end
        OP_DIV_MEAN: begin
          div_neg <= ysum[YSW-1];
        end
        OP_CAP_MEAN: begin
          mean <= div_neg ? -$signed(q64) : $signed(q64);
          idx  <= '0;
          tot  <= '0;
          res  <= '0;
        end
        OP_DEV: begin
          dev_t <= dev_mag(66'(yq) - 66'(mean));
          dev_r <= dev_mag(66'(yq) - 66'(pred));
        end
        OP_SQ: begin
          sq_t <= 64'(dev_t) * 64'(dev_t);
          sq_r <= 64'(dev_r) * 64'(dev_r);
        end
        OP_SQ_ACC: begin
          tot <= uadd_sat(tot, sq_t >> 16);
          res <= uadd_sat(res, sq_r >> 16);
          idx <= idx + 1'b1;
        end
        OP_FINAL: begin
          if (tot == '0) begin
            fit   <= '0;
            degen <= 1'b1;
          end else begin
            degen <= 1'b0;
            if (|div_quotient[95:48]) begin
              fit <= Q_MIN48;
            end else begin
              fit <= sat48(ONE_Q66 - $signed({18'd0, div_quotient[47:0]}));
            end
          end
        end
        OP_OUT: begin
          out_valid     <= 1'b1;
          out_slope     <= slope;
          out_intercept <= intercept;
          out_fit       <= fit;
          out_status    <= degen;
          count         <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    status.idx_last    = ((CW + 1)'(idx) + 1'b1) == (CW + 1)'(count);
    status.epochs_done = (epoch_cnt == epoch_count);
    status.div_busy    = div_busy;
    status.out_full    = out_valid && !out_ready;
    status.tot_zero    = (tot == '0);
  end

endmodule

// File: hdl/lrgd_ctrl.sv
module lrgd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  lrgd_pkg::status_t  status,
  output lrgd_pkg::cmd_t     cmd
);
  import lrgd_pkg::*;

  state_t state, state_next;
  logic   target, target_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      target <= 1'b0;
    end else begin
      state  <= state_next;
      target <= target_next;
    end
  end

  always_comb begin
    state_next  = state;
    target_next = target;
    case (state)
      ST_LOAD:        if (in_valid && in_last) state_next = ST_TRAIN_INIT;
      ST_TRAIN_INIT:  state_next = ST_EPOCH_CHECK;
      ST_EPOCH_CHECK: state_next = status.epochs_done ? ST_SCORE_INIT : ST_EPOCH_INIT;
      ST_EPOCH_INIT:  state_next = ST_G_READ;
      ST_G_READ:      state_next = ST_G_PMUL;
      ST_G_PMUL:      state_next = ST_G_PADD;
      ST_G_PADD:      state_next = ST_G_ERR;
      ST_G_ERR:       state_next = ST_G_GMUL;
      ST_G_GMUL:      state_next = ST_G_ACC;
      ST_G_ACC:       state_next = status.idx_last ? ST_DIV_START : ST_G_READ;
      ST_DIV_START:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:    if (!status.div_busy) state_next = ST_CAP_G;
      ST_CAP_G:       state_next = ST_RATE_MUL;
      ST_RATE_MUL:    state_next = ST_RATE_SUM;
      ST_RATE_SUM:    state_next = ST_UPDATE;
      ST_UPDATE: begin
        target_next = ~target;
        state_next  = target ? ST_EPOCH_CHECK : ST_DIV_START;
      end
      ST_SCORE_INIT:  state_next = ST_Y_READ;
      ST_Y_READ:      state_next = ST_Y_ACC;
      ST_Y_ACC:       state_next = status.idx_last ? ST_MEAN_START : ST_Y_READ;
      ST_MEAN_START:  state_next = ST_MEAN_WAIT;
      ST_MEAN_WAIT:   if (!status.div_busy) state_next = ST_MEAN_CAP;
      ST_MEAN_CAP:    state_next = ST_S_READ;
      ST_S_READ:      state_next = ST_S_PMUL;
      ST_S_PMUL:      state_next = ST_S_PADD;
      ST_S_PADD:      state_next = ST_S_DEV;
      ST_S_DEV:       state_next = ST_S_SQ;
      ST_S_SQ:        state_next = ST_S_ACC;
      ST_S_ACC:       state_next = status.idx_last ? ST_RATIO_CHECK : ST_S_READ;
      ST_RATIO_CHECK: state_next = status.tot_zero ? ST_FINAL : ST_RATIO_START;
      ST_RATIO_START: state_next = ST_RATIO_WAIT;
      ST_RATIO_WAIT:  if (!status.div_busy) state_next = ST_FINAL;
      ST_FINAL:       state_next = ST_OUT;
      ST_OUT:         if (!status.out_full) state_next = ST_LOAD;
      default:        state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd.op       = OP_NONE;
    cmd.target   = target;
    cmd.use_prev = 1'b0;
    in_ready     = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_STORE;
      end
      ST_TRAIN_INIT:  cmd.op = OP_TRAIN_INIT;
      ST_EPOCH_INIT:  cmd.op = OP_EPOCH_INIT;
      ST_G_PMUL:      cmd.op = OP_PRED_MUL;
      ST_G_PADD:      cmd.op = OP_PRED_ADD;
      ST_G_ERR:       cmd.op = OP_ERR;
      ST_G_GMUL:      cmd.op = OP_GRAD_MUL;
      ST_G_ACC:       cmd.op = OP_GRAD_ACC;
      ST_DIV_START:   cmd.op = OP_DIV_G;
      ST_CAP_G:       cmd.op = OP_CAP_G;
      ST_RATE_MUL:    cmd.op = OP_RATE_MUL;
      ST_RATE_SUM:    cmd.op = OP_RATE_SUM;
      ST_UPDATE:      cmd.op = OP_UPDATE;
      ST_SCORE_INIT:  cmd.op = OP_SCORE_INIT;
      ST_Y_ACC:       cmd.op = OP_Y_ACC;
      ST_MEAN_START:  cmd.op = OP_DIV_MEAN;
      ST_MEAN_CAP:    cmd.op = OP_CAP_MEAN;
      ST_S_PMUL: begin
        cmd.op       = OP_PRED_MUL;
        cmd.use_prev = 1'b1;
      end
      ST_S_PADD: begin
        cmd.op       = OP_PRED_ADD;
        cmd.use_prev = 1'b1;
      end
      ST_S_DEV:       cmd.op = OP_DEV;
      ST_S_SQ:        cmd.op = OP_SQ;
      ST_S_ACC:       cmd.op = OP_SQ_ACC;
      ST_RATIO_START: cmd.op = OP_DIV_RATIO;
      ST_FINAL:       cmd.op = OP_FINAL;
      ST_OUT:         if (!status.out_full) cmd.op = OP_OUT;
      default:        cmd.op = OP_NONE;
    endcase
  end

endmodule
